[design/assert_macros.svh]
// Assertion macros shared by the arc counter and the top-level design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("check failed");
`else
`define CHK_ASSERT(lbl, clk, rst, prop)
`define CHK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/tdmf_pkg.sv]
// Constants, types and mode codes of the table-driven Mealy machine
`timescale 1ns / 1ps
package tdmf_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;
  localparam int VALUE_WIDTH = 16;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SYM_W   = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W  = STATE_W + SYM_W;
  localparam int DEPTH   = NUM_STATES * NUM_SYMBOLS;
  localparam int CNT_W   = $clog2(NUM_SYMBOLS + 1);

  localparam logic signed [4:0]             NO_STATE = -5'sd1;
  localparam logic signed [VALUE_WIDTH-1:0] NO_VALUE = '1;

  typedef enum logic [1:0] {
    MODE_STEP      = 2'd0,
    MODE_SET_ARC   = 2'd1,
    MODE_SET_STATE = 2'd2,
    MODE_QUERY     = 2'd3
  } mode_t;

  typedef struct packed {
    logic en;
    logic remove;
  } arc_wr_t;

endpackage

[design/tdmf_arc_mem.sv]
// Arc store: next-state and output memory with per-entry valid bits
`timescale 1ns / 1ps
module tdmf_arc_mem (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    req,
  input  tdmf_pkg::arc_wr_t                       wr,
  input  logic [tdmf_pkg::ADDR_W-1:0]             addr,
  input  logic [tdmf_pkg::STATE_W-1:0]            wr_target,
  input  logic signed [tdmf_pkg::VALUE_WIDTH-1:0] wr_value,
  output logic                                    had,
  output logic                                    rd_valid,
  output logic [tdmf_pkg::STATE_W-1:0]            rd_target,
  output logic signed [tdmf_pkg::VALUE_WIDTH-1:0] rd_value
);

  logic [tdmf_pkg::DEPTH-1:0] valid;
  logic [tdmf_pkg::STATE_W+tdmf_pkg::VALUE_WIDTH-1:0] mem [tdmf_pkg::DEPTH];
  logic [tdmf_pkg::STATE_W+tdmf_pkg::VALUE_WIDTH-1:0] rd_word;

  assign had = valid[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[addr] <= ~wr.remove;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.remove) begin
      mem[addr] <= {wr_target, wr_value};
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      rd_word  <= mem[addr];
      rd_valid <= valid[addr];
    end
  end

  assign rd_target = rd_word[tdmf_pkg::STATE_W+tdmf_pkg::VALUE_WIDTH-1:tdmf_pkg::VALUE_WIDTH];
  assign rd_value  = rd_word[tdmf_pkg::VALUE_WIDTH-1:0];

endmodule

[design/tdmf_arc_count.sv]
// Per-state outgoing arc counters and the no-arc lookup
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tdmf_arc_count (
  input  logic                         clk,
  input  logic                         rst,
  input  tdmf_pkg::arc_wr_t            wr,
  input  logic                         had,
  input  logic [tdmf_pkg::STATE_W-1:0] wr_state,
  input  logic [tdmf_pkg::STATE_W-1:0] q_state,
  output logic                         q_zero
);

  logic [tdmf_pkg::CNT_W-1:0] cnt [tdmf_pkg::NUM_STATES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tdmf_pkg::NUM_STATES; i++) begin
        cnt[i] <= '0;
      end
    end else if (wr.en) begin
      if (wr.remove && had) begin
        cnt[wr_state] <= cnt[wr_state] - tdmf_pkg::CNT_W'(1);
      end else if (!wr.remove && !had) begin
        cnt[wr_state] <= cnt[wr_state] + tdmf_pkg::CNT_W'(1);
      end
    end
  end

  assign q_zero = (cnt[q_state] == '0);

  `CHK_ASSERT(a_remove_has_count, clk, rst, wr.en && wr.remove && had |-> cnt[wr_state] != '0)
  `CHK_ASSERT(a_add_below_full, clk, rst, wr.en && !wr.remove && !had |-> cnt[wr_state] != tdmf_pkg::CNT_W'(tdmf_pkg::NUM_SYMBOLS))

endmodule

[design/table_driven_mealy_fsm_top.sv]
// Top level of the table-driven Mealy machine
// One item is accepted in every cycle (busy stays low). Done is registered from s_vld, which
// is set at the accepting edge, and marks the result for exactly one cycle; results come out
// in item order and the receiver cannot stall them. The rate is set by the single-port arc
// memory: the address of each item is formed from the state left by the item one stage
// ahead, taken straight from that item's registered memory read, so transitions chain at
// one per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module table_driven_mealy_fsm_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              mode,
  input  logic [3:0]                              symbol,
  input  logic [3:0]                              arc_source,
  input  logic signed [4:0]                       target_state,
  input  logic signed [tdmf_pkg::VALUE_WIDTH-1:0] arc_value,
  output logic                                    done,
  output logic                                    arc_found,
  output logic signed [tdmf_pkg::VALUE_WIDTH-1:0] emitted_value,
  output logic signed [4:0]                       present_state,
  output logic                                    final_flag
);

  logic                                    accept;
  tdmf_pkg::mode_t                         in_mode;
  tdmf_pkg::arc_wr_t                       wr;
  logic [tdmf_pkg::ADDR_W-1:0]             addr;
  logic                                    had;
  logic                                    rd_valid;
  logic [tdmf_pkg::STATE_W-1:0]            rd_target;
  logic signed [tdmf_pkg::VALUE_WIDTH-1:0] rd_value;

  logic signed [4:0]                       ps_reg;
  logic signed [4:0]                       ps_next;
  logic signed [4:0]                       ps_after;
  logic                                    found;
  logic signed [tdmf_pkg::VALUE_WIDTH-1:0] emit;
  logic                                    q_zero;

  logic                                    s_vld;
  tdmf_pkg::mode_t                         s_mode;
  logic                                    s_have;
  logic signed [4:0]                       s_tgt;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign in_mode = tdmf_pkg::mode_t'(mode);

  assign wr.en     = accept && (in_mode == tdmf_pkg::MODE_SET_ARC);
  assign wr.remove = target_state[4];

  always_comb begin
    if (in_mode == tdmf_pkg::MODE_SET_ARC) begin
      addr = {arc_source[tdmf_pkg::STATE_W-1:0], symbol[tdmf_pkg::SYM_W-1:0]};
    end else begin
      addr = {ps_next[tdmf_pkg::STATE_W-1:0], symbol[tdmf_pkg::SYM_W-1:0]};
    end
  end

  tdmf_arc_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .req       (accept),
    .wr        (wr),
    .addr      (addr),
    .wr_target (target_state[tdmf_pkg::STATE_W-1:0]),
    .wr_value  (arc_value),
    .had       (had),
    .rd_valid  (rd_valid),
    .rd_target (rd_target),
    .rd_value  (rd_value)
  );

  tdmf_arc_count u_count (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .had      (had),
    .wr_state (arc_source[tdmf_pkg::STATE_W-1:0]),
    .q_state  (ps_after[tdmf_pkg::STATE_W-1:0]),
    .q_zero   (q_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_mode <= in_mode;
      s_have <= !ps_next[4];
      s_tgt  <= target_state;
    end
  end

  always_comb begin
    found    = 1'b0;
    emit     = tdmf_pkg::NO_VALUE;
    ps_after = ps_reg;
    case (s_mode)
      tdmf_pkg::MODE_STEP: begin
        if (s_have && rd_valid) begin
          found    = 1'b1;
          emit     = rd_value;
          ps_after = signed'({1'b0, rd_target});
        end
      end
      tdmf_pkg::MODE_SET_STATE: begin
        ps_after = s_tgt[4] ? tdmf_pkg::NO_STATE : s_tgt;
      end
      default: begin
      end
    endcase
  end

  assign ps_next = s_vld ? ps_after : ps_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps_reg <= tdmf_pkg::NO_STATE;
      done   <= 1'b0;
    end else begin
      ps_reg <= ps_next;
      done   <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld) begin
      arc_found     <= found;
      emitted_value <= emit;
      present_state <= ps_after;
      final_flag    <= !ps_after[4] && q_zero;
    end
  end

  `CHK_ASSERT(a_done_follows_accept, clk, rst, done |-> $past(start && !busy, 2))
  `CHK_ASSERT(a_taken_arc_has_state, clk, rst, done && arc_found |-> !present_state[4])
  `CHK_ASSERT(a_no_state_not_final, clk, rst, done && present_state[4] |-> !final_flag)
  `CHK_ASSERT_ALWAYS(a_reset_clears_done, clk, rst |=> !done)

endmodule
